FILE: src/i2cm_pkg.sv
package i2cm_pkg;

	// Number of bytes fetched by one burst read.
	localparam int READ_BYTES = 6;
	localparam logic [3:0] READ_BYTES_W = 4'(READ_BYTES);

	// Default depth of the queue between the front stage and the sequencer.
	localparam int QUEUE_DEPTH = 4;

	// Configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DEVICE_ADDRESS = 3'd0,
		CFG_OPEN_DRAIN     = 3'd1,
		CFG_HALF_BIT       = 3'd2,
		CFG_STRETCH_TMO    = 3'd3,
		CFG_PHASE_GAP      = 3'd4,
		CFG_BYTE_GAP       = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [6:0]  device_address;
		logic        open_drain;
		logic [7:0]  half_bit_ticks;
		logic [15:0] stretch_timeout_ticks;
		logic [15:0] phase_gap_ticks;
		logic [7:0]  byte_gap_ticks;
	} cfg_t;

	// One timebase tick as it travels from the front stage to the sequencer.
	typedef struct packed {
		logic       cmd_valid;
		logic       mode;
		logic [7:0] reg_addr;
		logic [7:0] write_value;
		logic       sda_in;
		logic       scl_in;
	} item_t;

	// Transaction phases.
	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_START_W  = 5'd1,
		PH_ADDR_W   = 5'd2,
		PH_ACK_A    = 5'd3,
		PH_REG      = 5'd4,
		PH_ACK_R    = 5'd5,
		PH_VAL      = 5'd6,
		PH_ACK_V    = 5'd7,
		PH_STOP_END = 5'd8,
		PH_STOP_MID = 5'd9,
		PH_GAP      = 5'd10,
		PH_START_R  = 5'd11,
		PH_ADDR_R   = 5'd12,
		PH_ACK_AR   = 5'd13,
		PH_BGAP     = 5'd14,
		PH_RBYTE    = 5'd15,
		PH_MACK     = 5'd16
	} phase_t;

	// Line operations, one executed per tick unless a wait or clock stretch is pending.
	typedef enum logic [3:0] {
		OP_END  = 4'd0,
		OP_DH   = 4'd1,
		OP_DL   = 4'd2,
		OP_DR   = 4'd3,
		OP_DBIT = 4'd4,
		OP_DACK = 4'd5,
		OP_CH   = 4'd6,
		OP_CL   = 4'd7,
		OP_SMP  = 4'd8,
		OP_GAP  = 4'd9,
		OP_BGAP = 4'd10
	} op_t;

	// Operation sequence used by a phase.
	typedef enum logic [2:0] {
		K_START = 3'd0,
		K_WBIT  = 3'd1,
		K_ACKW  = 3'd2,
		K_STOP  = 3'd3,
		K_GAP   = 3'd4,
		K_BGAP  = 3'd5,
		K_RBIT  = 3'd6,
		K_MACK  = 3'd7
	} kind_t;

	function automatic kind_t kind_of(input phase_t ph);
		kind_t k;
		case (ph)
			PH_IDLE:     k = K_GAP;
			PH_START_W:  k = K_START;
			PH_ADDR_W:   k = K_WBIT;
			PH_ACK_A:    k = K_ACKW;
			PH_REG:      k = K_WBIT;
			PH_ACK_R:    k = K_ACKW;
			PH_VAL:      k = K_WBIT;
			PH_ACK_V:    k = K_ACKW;
			PH_STOP_END: k = K_STOP;
			PH_STOP_MID: k = K_STOP;
			PH_GAP:      k = K_GAP;
			PH_START_R:  k = K_START;
			PH_ADDR_R:   k = K_WBIT;
			PH_ACK_AR:   k = K_ACKW;
			PH_BGAP:     k = K_BGAP;
			PH_RBYTE:    k = K_RBIT;
			PH_MACK:     k = K_MACK;
			default:     k = K_GAP;
		endcase
		return k;
	endfunction

	// Operation at a given position of a sequence; past its end reads OP_END.
	function automatic op_t seq_op(input kind_t k, input logic [2:0] pos);
		op_t op;
		op = OP_END;
		case (k)
			K_START: begin
				case (pos)
					3'd0: op = OP_DH;
					3'd1: op = OP_CH;
					3'd2: op = OP_DL;
					3'd3: op = OP_CL;
					default: op = OP_END;
				endcase
			end
			K_WBIT: begin
				case (pos)
					3'd0: op = OP_DBIT;
					3'd1: op = OP_CH;
					3'd2: op = OP_CL;
					default: op = OP_END;
				endcase
			end
			K_ACKW: begin
				case (pos)
					3'd0: op = OP_DR;
					3'd1: op = OP_CH;
					3'd2: op = OP_CL;
					default: op = OP_END;
				endcase
			end
			K_STOP: begin
				case (pos)
					3'd0: op = OP_CL;
					3'd1: op = OP_DL;
					3'd2: op = OP_CH;
					3'd3: op = OP_DH;
					3'd4: op = OP_DR;
					default: op = OP_END;
				endcase
			end
			K_GAP: begin
				case (pos)
					3'd0: op = OP_GAP;
					default: op = OP_END;
				endcase
			end
			K_BGAP: begin
				case (pos)
					3'd0: op = OP_BGAP;
					3'd1: op = OP_DR;
					default: op = OP_END;
				endcase
			end
			K_RBIT: begin
				case (pos)
					3'd0: op = OP_CH;
					3'd1: op = OP_SMP;
					3'd2: op = OP_CL;
					default: op = OP_END;
				endcase
			end
			K_MACK: begin
				case (pos)
					3'd0: op = OP_CL;
					3'd1: op = OP_DACK;
					3'd2: op = OP_CH;
					3'd3: op = OP_CL;
					3'd4: op = OP_DR;
					default: op = OP_END;
				endcase
			end
			default: op = OP_END;
		endcase
		return op;
	endfunction

endpackage

FILE: src/i2cm_front.sv
module i2cm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           cmd_valid,
	input  logic           mode,
	input  logic [7:0]     reg_addr,
	input  logic [7:0]     write_value,
	input  logic           sda_in,
	input  logic           scl_in,
	input  logic           queue_full,
	output logic           push,
	output i2cm_pkg::item_t item_s1
);
	import i2cm_pkg::*;

	logic valid_s1;

	// The stage holds its tick only while the queue has no room for it.
	assign in_stall = valid_s1 & queue_full;
	assign push     = valid_s1 & ~queue_full;

	// Valid flag of the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input stage; a command bit is only kept when the tick is real.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.cmd_valid   <= cmd_valid;
			item_s1.mode        <= mode;
			item_s1.reg_addr    <= reg_addr;
			item_s1.write_value <= write_value;
			item_s1.sda_in      <= sda_in;
			item_s1.scl_in      <= scl_in;
		end
	end

endmodule

FILE: src/i2cm_queue.sv
module i2cm_queue #(
	parameter int Depth = i2cm_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cm_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output i2cm_pkg::item_t head
);
	import i2cm_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	item_t            entries_q [Depth];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CntW'(Depth));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = entries_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_q] <= push_item;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("queue fill count exceeds its depth");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue fill count missed a transfer in");

endmodule

FILE: src/i2cm_seq.sv
module i2cm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  i2cm_pkg::cfg_t  cfg,
	input  logic            empty,
	input  i2cm_pkg::item_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            scl_level,
	output logic            sda_level,
	output logic            sda_driven,
	output logic            busy_res,
	output logic            read_valid,
	output logic [7:0]      read_byte,
	output logic            read_last
);
	import i2cm_pkg::*;

	// Sequencer state.
	phase_t      ph_q, ph_n;
	logic [2:0]  sub_q, sub_n;
	logic [2:0]  bit_q, bit_n;
	logic [2:0]  byte_q, byte_n;
	logic [7:0]  shift_q, shift_n;
	logic [15:0] wait_q, wait_n;
	logic        lmode_q, lmode_n;
	logic [7:0]  lreg_q, lreg_n;
	logic [7:0]  lval_q, lval_n;
	logic        str_q, str_n;
	logic        scl_q, scl_n;
	logic        sdal_q, sdal_n;
	logic        sdad_q, sdad_n;

	// Step results.
	logic        rv;
	logic [7:0]  rb;
	logic        rl;
	kind_t       kind;
	op_t         op;
	logic [2:0]  sh;
	logic [2:0]  sub_inc;
	logic        last;
	logic [7:0]  tx;

	// Result register.
	logic        out_valid_q;
	logic        scl_level_q, sda_level_q, sda_driven_q, busy_q;
	logic        read_valid_q, read_last_q;
	logic [7:0]  read_byte_q;

	// One tick is taken from a non-empty queue whenever the result register is free or being drained.
	assign pop = ~empty & (~out_valid_q | ~out_stall);

	assign kind    = kind_of(ph_q);
	assign op      = seq_op(kind, sub_q);
	assign sh      = 3'd7 - bit_q;
	assign sub_inc = sub_q + 3'd1;
	assign last    = ({1'b0, byte_q} + 4'd1) >= READ_BYTES_W;

	// Byte shifted out in the current write phase.
	always_comb begin
		case (ph_q)
			PH_ADDR_W: tx = {cfg.device_address, 1'b0};
			PH_ADDR_R: tx = {cfg.device_address, 1'b1};
			PH_REG:    tx = lreg_q;
			default:   tx = lval_q;
		endcase
	end

	// Next state of the sequencer for one tick.
	always_comb begin
		ph_n    = ph_q;
		sub_n   = sub_q;
		bit_n   = bit_q;
		byte_n  = byte_q;
		shift_n = shift_q;
		wait_n  = wait_q;
		lmode_n = lmode_q;
		lreg_n  = lreg_q;
		lval_n  = lval_q;
		str_n   = str_q;
		scl_n   = scl_q;
		sdal_n  = sdal_q;
		sdad_n  = sdad_q;
		rv      = 1'b0;
		rb      = 8'd0;
		rl      = 1'b0;
		if (ph_q == PH_IDLE) begin
			if (head.cmd_valid) begin
				lmode_n = head.mode;
				lreg_n  = head.reg_addr;
				lval_n  = head.write_value;
				ph_n    = PH_START_W;
				sub_n   = 3'd0;
				bit_n   = 3'd0;
				byte_n  = 3'd0;
				wait_n  = 16'd0;
				str_n   = 1'b0;
			end
		end else if (str_q) begin
			// Clock stretching: wait for the line or give up at the timeout.
			if (head.scl_in || wait_q >= cfg.stretch_timeout_ticks) begin
				str_n  = 1'b0;
				wait_n = {8'd0, cfg.half_bit_ticks};
			end else begin
				wait_n = wait_q + 16'd1;
			end
		end else if (wait_q != 16'd0) begin
			wait_n = wait_q - 16'd1;
		end else begin
			case (op)
				OP_DH: begin
					sdad_n = ~cfg.open_drain;
					sdal_n = 1'b1;
				end
				OP_DL: begin
					sdad_n = 1'b1;
					sdal_n = 1'b0;
				end
				OP_DR: begin
					sdad_n = 1'b0;
					sdal_n = 1'b1;
				end
				OP_DBIT: begin
					sdad_n = tx[sh] ? ~cfg.open_drain : 1'b1;
					sdal_n = tx[sh];
				end
				OP_DACK: begin
					sdad_n = last ? ~cfg.open_drain : 1'b1;
					sdal_n = last;
				end
				OP_CH: begin
					scl_n = 1'b1;
					if (cfg.open_drain) begin
						str_n  = 1'b1;
						wait_n = 16'd0;
					end else begin
						wait_n = {8'd0, cfg.half_bit_ticks};
					end
				end
				OP_CL: begin
					scl_n  = 1'b0;
					wait_n = {8'd0, cfg.half_bit_ticks};
				end
				OP_SMP: begin
					shift_n     = shift_q;
					shift_n[sh] = shift_q[sh] | head.sda_in;
					if (sh == 3'd0) begin
						rv = 1'b1;
						rb = shift_n;
						rl = last;
					end
				end
				OP_GAP: wait_n = cfg.phase_gap_ticks;
				OP_BGAP: begin
					wait_n  = {8'd0, cfg.byte_gap_ticks};
					shift_n = 8'd0;
				end
				default: ;
			endcase
			// Advance within the sequence, then over bits, then over phases.
			if (sub_inc >= 3'd6 || seq_op(kind, sub_inc) == OP_END) begin
				sub_n = 3'd0;
				if ((kind == K_WBIT || kind == K_RBIT) && bit_q < 3'd7) begin
					bit_n = bit_q + 3'd1;
				end else begin
					bit_n = 3'd0;
					case (ph_q)
						PH_ACK_R:    ph_n = lmode_q ? PH_STOP_MID : PH_VAL;
						PH_STOP_END: ph_n = PH_IDLE;
						PH_ACK_AR: begin
							byte_n = 3'd0;
							ph_n   = PH_BGAP;
						end
						PH_MACK: begin
							if (last) begin
								ph_n = PH_STOP_END;
							end else begin
								byte_n = byte_q + 3'd1;
								ph_n   = PH_BGAP;
							end
						end
						default: ph_n = phase_t'(ph_q + 5'd1);
					endcase
				end
			end else begin
				sub_n = sub_inc;
			end
		end
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			sub_q   <= 3'd0;
			bit_q   <= 3'd0;
			byte_q  <= 3'd0;
			shift_q <= 8'd0;
			wait_q  <= 16'd0;
			lmode_q <= 1'b0;
			lreg_q  <= 8'd0;
			lval_q  <= 8'd0;
			str_q   <= 1'b0;
			scl_q   <= 1'b1;
			sdal_q  <= 1'b1;
			sdad_q  <= 1'b0;
		end else if (pop) begin
			ph_q    <= ph_n;
			sub_q   <= sub_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			wait_q  <= wait_n;
			lmode_q <= lmode_n;
			lreg_q  <= lreg_n;
			lval_q  <= lval_n;
			str_q   <= str_n;
			scl_q   <= scl_n;
			sdal_q  <= sdal_n;
			sdad_q  <= sdad_n;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded with each tick's line levels and read byte.
	always_ff @(posedge clk) begin
		if (pop) begin
			scl_level_q  <= scl_n;
			sda_level_q  <= sdad_n ? sdal_n : 1'b1;
			sda_driven_q <= sdad_n;
			busy_q       <= (ph_n != PH_IDLE);
			read_valid_q <= rv;
			read_byte_q  <= rb;
			read_last_q  <= rl;
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_level  = scl_level_q;
	assign sda_level  = sda_level_q;
	assign sda_driven = sda_driven_q;
	assign busy_res   = busy_q;
	assign read_valid = read_valid_q;
	assign read_byte  = read_byte_q;
	assign read_last  = read_last_q;

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_IDLE) |-> (!str_q && wait_q == 16'd0 && sub_q == 3'd0))
		else $error("idle sequencer holds a pending wait or sequence position");

	a_read_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && rv) |-> (ph_q == PH_RBYTE && bit_q == 3'd7))
		else $error("read byte completed outside the last bit of a read byte");

	a_stretch_od: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !str_q && str_n) |-> cfg.open_drain)
		else $error("clock stretch wait entered in push-pull mode");

endmodule

FILE: src/i2c_master_register_access.sv
// Bit-level I2C master for register writes and six-byte burst reads. Each
// input transfer is one timebase tick carrying the sampled SDA/SCL levels and
// an optional command; each tick gives exactly one output transfer with the
// clock and data line levels to drive, the busy flag, and any byte just read
// (read_valid, read_byte, read_last on the final byte of a burst). A command
// is taken only while the master is idle. The block takes one tick per clock
// cycle while the output side does not stall: a one-tick sequencer step behind
// an input register and a small queue sets that figure; a tick passes via the
// input register and a queue entry to the output register. The queue lets the
// input side keep accepting while the output side is stalled, until it fills.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// take effect from the next tick; indexes beyond the list are ignored.
module i2c_master_register_access #(
	parameter int QueueDepth = i2cm_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [i2cm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd_valid,
	input  logic                             mode,
	input  logic [7:0]                       reg_addr,
	input  logic [7:0]                       write_value,
	input  logic                             sda_in,
	input  logic                             scl_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             scl_level,
	output logic                             sda_level,
	output logic                             sda_driven,
	output logic                             busy_res,
	output logic                             read_valid,
	output logic [7:0]                       read_byte,
	output logic                             read_last
);
	import i2cm_pkg::*;

	cfg_t  cfg_q;
	item_t item_s1;
	item_t head;
	logic  push;
	logic  queue_full;
	logic  pop;
	logic  empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address        <= 7'd82;
			cfg_q.open_drain            <= 1'b0;
			cfg_q.half_bit_ticks        <= 8'd1;
			cfg_q.stretch_timeout_ticks <= 16'd100;
			cfg_q.phase_gap_ticks       <= 16'd1000;
			cfg_q.byte_gap_ticks        <= 8'd40;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS: cfg_q.device_address        <= cfg_data[6:0];
				CFG_OPEN_DRAIN:     cfg_q.open_drain            <= cfg_data[0];
				CFG_HALF_BIT:       cfg_q.half_bit_ticks        <= cfg_data[7:0];
				CFG_STRETCH_TMO:    cfg_q.stretch_timeout_ticks <= cfg_data;
				CFG_PHASE_GAP:      cfg_q.phase_gap_ticks       <= cfg_data;
				CFG_BYTE_GAP:       cfg_q.byte_gap_ticks        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input stage.
	i2cm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd_valid   (cmd_valid),
		.mode        (mode),
		.reg_addr    (reg_addr),
		.write_value (write_value),
		.sda_in      (sda_in),
		.scl_in      (scl_in),
		.queue_full  (queue_full),
		.push        (push),
		.item_s1     (item_s1)
	);

	// Tick queue between the input stage and the sequencer.
	i2cm_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (item_s1),
		.full      (queue_full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	// Bus sequencer and output register.
	i2cm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.sda_driven (sda_driven),
		.busy_res   (busy_res),
		.read_valid (read_valid),
		.read_byte  (read_byte),
		.read_last  (read_last)
	);

endmodule
